>>> hdl/otpc_pkg.sv
// otpc_pkg: shared types, offsets, record layout table and crc step
// for the calibration image check and repack unit; no dependencies
`timescale 1ns / 1ps
package otpc_pkg;

  localparam int IMAGE_BYTES = 622;
  localparam int AW          = 10;
  localparam int CW          = 6;
  localparam int WORD_BYTES  = 16;
  localparam int VB_W        = 5;

  localparam logic [AW-1:0] GRID_STRIDE = AW'(63);
  localparam logic [AW-1:0] GRID1_BASE  = AW'(81);
  localparam logic [AW-1:0] GRID2_BASE  = AW'(354);
  localparam logic [AW-1:0] LAST_POS    = AW'(IMAGE_BYTES - 1);

  localparam logic [5:0] FIX_HDR_LAST = 6'd20;
  localparam logic [5:0] FIX_MID      = 6'd21;
  localparam logic [5:0] FIX_LAST     = 6'd37;

  localparam logic [7:0] LIGHT_COUNT = 8'h02;

  typedef enum logic [2:0] {
    ST_OK, ST_MODULE, ST_FOCUS, ST_SRC1, ST_SRC2, ST_TOTAL, ST_CROSS, ST_FORMAT
  } status_t;

  typedef struct packed {
    status_t       status;
    logic [CW-1:0] cells;
  } chk_t;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic          low2;
    logic          one;
  } fix_t;

  // fixed record bytes: header, source2 fraction, white-balance gains
  function automatic fix_t fix_entry(input logic [5:0] idx);
    fix_t f;
    f = '{addr: '0, low2: 1'b0, one: 1'b0};
    unique case (idx)
      6'd0:  f.addr = AW'(73);
      6'd1:  f.addr = AW'(74);
      6'd2:  f.one  = 1'b1;
      6'd3:  f.addr = AW'(52);
      6'd4:  f.addr = AW'(53);
      6'd5:  f.addr = AW'(57);
      6'd6:  f = '{addr: AW'(56), low2: 1'b1, one: 1'b0};
      6'd7:  f.addr = AW'(55);
      6'd8:  f = '{addr: AW'(54), low2: 1'b1, one: 1'b0};
      6'd9:  f.addr = AW'(55);
      6'd10: f = '{addr: AW'(54), low2: 1'b1, one: 1'b0};
      6'd11: f.addr = AW'(57);
      6'd12: f = '{addr: AW'(56), low2: 1'b1, one: 1'b0};
      6'd13: f.addr = AW'(75);
      6'd14: f.addr = AW'(76);
      6'd15: f.addr = AW'(349);
      6'd16: f.addr = AW'(77);
      6'd17: f.addr = AW'(350);
      6'd18: f.addr = AW'(78);
      6'd19: f.addr = AW'(79);
      6'd20: f.addr = AW'(80);
      6'd21: f.addr = AW'(353);
      6'd22: f.addr = AW'(333);
      6'd23: f.addr = AW'(334);
      6'd24: f.addr = AW'(606);
      6'd25: f.addr = AW'(607);
      6'd26: f.addr = AW'(335);
      6'd27: f.addr = AW'(336);
      6'd28: f.addr = AW'(608);
      6'd29: f.addr = AW'(609);
      6'd30: f.addr = AW'(337);
      6'd31: f.addr = AW'(338);
      6'd32: f.addr = AW'(610);
      6'd33: f.addr = AW'(611);
      6'd34: f.addr = AW'(339);
      6'd35: f.addr = AW'(340);
      6'd36: f.addr = AW'(612);
      6'd37: f.addr = AW'(613);
      default: f.addr = '0;
    endcase
    return f;
  endfunction

  // reflected crc-16, poly 0xa001, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) r = (r >> 1) ^ 16'hA001;
      else r = r >> 1;
    end
    return r;
  endfunction

endpackage

>>> hdl/otpc_if.sv
// otpc_if: input and result channel interfaces
// depends on nothing
`timescale 1ns / 1ps
interface otpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] otp_byte;
  modport source (output valid, output otp_byte, input ready);
  modport sink (input valid, input otp_byte, output ready);
endinterface

interface otpc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] word_low;
  logic [63:0] word_high;
  logic [4:0]  valid_bytes;
  logic [2:0]  status;
  logic        last;
  modport source (output valid, output word_low, output word_high, output valid_bytes,
                  output status, output last, input ready);
  modport sink (input valid, input word_low, input word_high, input valid_bytes,
                input status, input last, output ready);
endinterface

>>> hdl/otp_calibration_check_and_repack_unit.sv
// otp_calibration_check_and_repack_unit: top level of the calibration checker
// depends on otpc_pkg, otpc_if, otpc_mem, otpc_accum, otpc_repack
//
//   channel   dir  handshake     payload
//   in_ch     in   valid/ready   otp_byte
//   out_ch    out  valid/ready   word_low, word_high, valid_bytes, status, last
//
// load: one byte per cycle while ready, sums kept on the fly, bytes go to the store
// after the final byte: a check state, then a read state and a byte state per record byte
// (one store read port, registered read), and an emit state per emitted word
// a record is n = 40 + 8*cells bytes; an error gives a single result word
// no input is taken during check and repack; output stalls hold the sequencer
// synchronous active-low reset, store contents are not cleared
`timescale 1ns / 1ps
module otp_calibration_check_and_repack_unit #(
  parameter int GRID_CELLS = 63
) (
  input logic        clk,
  input logic        rst_n,
  otpc_in_if.sink    in_ch,
  otpc_out_if.source out_ch
);
  logic                    in_fire, at_end, clr_sums, in_ready, rd_en;
  logic [otpc_pkg::AW-1:0] pos, rd_addr;
  logic [7:0]              rd_data;
  otpc_pkg::chk_t          chk;

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  otpc_accum #(.GRID_CELLS(GRID_CELLS)) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (in_fire),
    .byte_in (in_ch.otp_byte),
    .clr     (clr_sums),
    .pos     (pos),
    .at_end  (at_end),
    .chk     (chk)
  );

  otpc_mem u_mem (
    .clk   (clk),
    .we    (in_fire),
    .waddr (pos),
    .wdata (in_ch.otp_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  otpc_repack u_repack (
    .clk      (clk),
    .rst_n    (rst_n),
    .img_done (in_fire && at_end),
    .chk      (chk),
    .clr_sums (clr_sums),
    .in_ready (in_ready),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .out_ch   (out_ch)
  );
endmodule

>>> hdl/otpc_mem.sv
// otpc_mem: image byte store, one write port, one registered read port
// depends on otpc_pkg
`timescale 1ns / 1ps
module otpc_mem (
  input  logic                    clk,
  input  logic                    we,
  input  logic [otpc_pkg::AW-1:0] waddr,
  input  logic [7:0]              wdata,
  input  logic                    re,
  input  logic [otpc_pkg::AW-1:0] raddr,
  output logic [7:0]              rdata
);
  logic [7:0] mem_r [otpc_pkg::IMAGE_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

>>> hdl/otpc_accum.sv
// otpc_accum: load position, section sums, checksum byte capture and checks
// depends on otpc_pkg
`timescale 1ns / 1ps
module otpc_accum #(
  parameter int GRID_CELLS = 63
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    take,
  input  logic [7:0]              byte_in,
  input  logic                    clr,
  output logic [otpc_pkg::AW-1:0] pos,
  output logic                    at_end,
  output otpc_pkg::chk_t          chk
);
  logic [otpc_pkg::AW-1:0] pos_r;
  logic [15:0] s_mod_r, s_foc_r, s_src1_r, s_src2_r, s_tot_r, s_crs_r;
  logic [7:0]  b48_r, b49_r, b70_r, b71_r, b343_r, b344_r, b616_r, b617_r;
  logic [7:0]  b618_r, b619_r, b620_r, b621_r, b75_r, b78_r, b79_r;
  logic [15:0] bx;
  logic [15:0] prod;

  assign bx     = {8'h00, byte_in};
  assign pos    = pos_r;
  assign at_end = (pos_r == otpc_pkg::LAST_POS);

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      s_mod_r  <= '0;
      s_foc_r  <= '0;
      s_src1_r <= '0;
      s_src2_r <= '0;
      s_tot_r  <= '0;
      s_crs_r  <= '0;
    end else if (take) begin
      if (pos_r < 10'd48) s_mod_r <= s_mod_r + bx;
      if (pos_r >= 10'd50 && pos_r <= 10'd69) s_foc_r <= s_foc_r + bx;
      if (pos_r >= 10'd72 && pos_r <= 10'd342) s_src1_r <= s_src1_r + bx;
      if (pos_r >= 10'd345 && pos_r <= 10'd617) s_src2_r <= s_src2_r + bx;
      if (pos_r < 10'd620) s_tot_r <= s_tot_r + bx;
      if ((pos_r >= 10'd51 && pos_r <= 10'd67) || (pos_r >= 10'd73 && pos_r <= 10'd340)
          || (pos_r >= 10'd346 && pos_r <= 10'd613))
        s_crs_r <= s_crs_r + bx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (take) begin
      pos_r <= at_end ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      unique case (pos_r)
        10'd48:  b48_r  <= byte_in;
        10'd49:  b49_r  <= byte_in;
        10'd70:  b70_r  <= byte_in;
        10'd71:  b71_r  <= byte_in;
        10'd75:  b75_r  <= byte_in;
        10'd78:  b78_r  <= byte_in;
        10'd79:  b79_r  <= byte_in;
        10'd343: b343_r <= byte_in;
        10'd344: b344_r <= byte_in;
        10'd616: b616_r <= byte_in;
        10'd617: b617_r <= byte_in;
        10'd618: b618_r <= byte_in;
        10'd619: b619_r <= byte_in;
        10'd620: b620_r <= byte_in;
        10'd621: b621_r <= byte_in;
        default: ;
      endcase
    end
  end

  assign prod = b78_r * b79_r;

  always_comb begin
    chk.cells = prod[otpc_pkg::CW-1:0];
    if (s_mod_r != {b48_r, b49_r})          chk.status = otpc_pkg::ST_MODULE;
    else if (s_foc_r != {b70_r, b71_r})     chk.status = otpc_pkg::ST_FOCUS;
    else if (s_src1_r != {b343_r, b344_r})  chk.status = otpc_pkg::ST_SRC1;
    else if (s_src2_r != {b618_r, b619_r})  chk.status = otpc_pkg::ST_SRC2;
    else if (s_tot_r != {b620_r, b621_r})   chk.status = otpc_pkg::ST_TOTAL;
    else if (s_crs_r != {b617_r, b616_r})   chk.status = otpc_pkg::ST_CROSS;
    else if (b75_r != otpc_pkg::LIGHT_COUNT || prod > 16'(GRID_CELLS))
      chk.status = otpc_pkg::ST_FORMAT;
    else chk.status = otpc_pkg::ST_OK;
  end
endmodule

>>> hdl/otpc_repack.sv
// otpc_repack: sequencer that walks the store, builds record words and crc
// depends on otpc_pkg and otpc_if
`timescale 1ns / 1ps
module otpc_repack (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    img_done,
  input  otpc_pkg::chk_t          chk,
  output logic                    clr_sums,
  output logic                    in_ready,
  output logic                    rd_en,
  output logic [otpc_pkg::AW-1:0] rd_addr,
  input  logic [7:0]              rd_data,
  otpc_out_if.source              out_ch
);
  typedef enum logic [2:0] {S_LOAD, S_CHECK, S_ERR, S_READ, S_BYTE, S_EMIT} state_t;
  typedef enum logic [2:0] {P_HDR, P_GRID1, P_MID, P_GRID2, P_GAIN, P_CRC} phase_t;

  state_t                  st_r;
  phase_t                  ph_r;
  logic [5:0]              fix_r;
  logic [otpc_pkg::CW-1:0] cell_r, cells_r;
  logic [1:0]              chan_r;
  logic [otpc_pkg::AW-1:0] gaddr_r, cbase_r;
  logic [15:0]             crc_r;
  logic                    crcsel_r;
  logic [15:0][7:0]        buf_r;
  logic [otpc_pkg::VB_W-1:0] cnt_r;
  logic                    last_r;
  otpc_pkg::status_t       err_st_r;
  logic                    ov_r, olast_r;
  logic [63:0]             olo_r, ohi_r;
  logic [otpc_pkg::VB_W-1:0] ovb_r;
  otpc_pkg::status_t       ost_r;

  otpc_pkg::fix_t fe;
  logic           is_grid, out_free, lastb, ov_set;
  logic [7:0]     bval;

  assign fe       = otpc_pkg::fix_entry(fix_r);
  assign is_grid  = (ph_r == P_GRID1) || (ph_r == P_GRID2);
  assign rd_addr  = is_grid ? gaddr_r : fe.addr;
  assign rd_en    = (st_r == S_READ);
  assign in_ready = (st_r == S_LOAD);
  assign clr_sums = (st_r == S_CHECK);
  assign out_free = !ov_r || out_ch.ready;
  assign lastb    = (ph_r == P_CRC) && crcsel_r;
  assign ov_set   = ((st_r == S_ERR) || (st_r == S_EMIT)) && out_free;

  always_comb begin
    if (is_grid) bval = rd_data;
    else if (ph_r == P_CRC) bval = crcsel_r ? crc_r[15:8] : crc_r[7:0];
    else if (fe.one) bval = 8'h01;
    else if (fe.low2) bval = {6'b0, rd_data[1:0]};
    else bval = rd_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_LOAD;
      ph_r    <= P_HDR;
      fix_r   <= '0;
      cnt_r   <= '0;
      last_r  <= 1'b0;
      ov_r    <= 1'b0;
      ost_r   <= otpc_pkg::ST_OK;
      ovb_r   <= '0;
      olast_r <= 1'b0;
    end else begin
      ov_r <= ov_set || (ov_r && !out_ch.ready);
      unique case (st_r)
        S_LOAD: begin
          if (img_done) st_r <= S_CHECK;
        end
        S_CHECK: begin
          cells_r  <= chk.cells;
          err_st_r <= chk.status;
          ph_r     <= P_HDR;
          fix_r    <= '0;
          crc_r    <= '0;
          crcsel_r <= 1'b0;
          cnt_r    <= '0;
          buf_r    <= '0;
          last_r   <= 1'b0;
          st_r     <= (chk.status != otpc_pkg::ST_OK) ? S_ERR : S_READ;
        end
        S_ERR: begin
          if (out_free) begin
            olo_r   <= '0;
            ohi_r   <= '0;
            ovb_r   <= '0;
            ost_r   <= err_st_r;
            olast_r <= 1'b1;
            st_r    <= S_LOAD;
          end
        end
        S_READ: begin
          st_r <= S_BYTE;
        end
        S_BYTE: begin
          buf_r[cnt_r[3:0]] <= bval;
          cnt_r <= cnt_r + 1'b1;
          if (ph_r != P_CRC) crc_r <= otpc_pkg::crc16_byte(crc_r, bval);
          if (cnt_r == otpc_pkg::VB_W'(otpc_pkg::WORD_BYTES - 1) || lastb) begin
            last_r <= lastb;
            st_r   <= S_EMIT;
          end else begin
            st_r <= S_READ;
          end
          unique case (ph_r)
            P_HDR, P_MID: begin
              fix_r   <= fix_r + 1'b1;
              gaddr_r <= (ph_r == P_HDR) ? otpc_pkg::GRID1_BASE : otpc_pkg::GRID2_BASE;
              cbase_r <= (ph_r == P_HDR) ? otpc_pkg::GRID1_BASE : otpc_pkg::GRID2_BASE;
              cell_r  <= '0;
              chan_r  <= '0;
              if (fix_r == otpc_pkg::FIX_HDR_LAST)
                ph_r <= (cells_r == '0) ? P_MID : P_GRID1;
              else if (fix_r == otpc_pkg::FIX_MID)
                ph_r <= (cells_r == '0) ? P_GAIN : P_GRID2;
            end
            P_GRID1, P_GRID2: begin
              gaddr_r <= gaddr_r + 1'b1;
              cell_r  <= cell_r + 1'b1;
              if (cell_r == cells_r - 1'b1) begin
                cell_r <= '0;
                if (chan_r == 2'd3) begin
                  ph_r <= (ph_r == P_GRID1) ? P_MID : P_GAIN;
                end else begin
                  chan_r  <= chan_r + 1'b1;
                  gaddr_r <= cbase_r + otpc_pkg::GRID_STRIDE;
                  cbase_r <= cbase_r + otpc_pkg::GRID_STRIDE;
                end
              end
            end
            P_GAIN: begin
              fix_r <= fix_r + 1'b1;
              if (fix_r == otpc_pkg::FIX_LAST) begin
                ph_r     <= P_CRC;
                crcsel_r <= 1'b0;
              end
            end
            P_CRC: crcsel_r <= 1'b1;
            default: ;
          endcase
        end
        S_EMIT: begin
          if (out_free) begin
            olo_r   <= buf_r[7:0];
            ohi_r   <= buf_r[15:8];
            ovb_r   <= cnt_r;
            ost_r   <= otpc_pkg::ST_OK;
            olast_r <= last_r;
            buf_r   <= '0;
            cnt_r   <= '0;
            st_r    <= last_r ? S_LOAD : S_READ;
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.word_low    = olo_r;
  assign out_ch.word_high   = ohi_r;
  assign out_ch.valid_bytes = ovb_r;
  assign out_ch.status      = ost_r;
  assign out_ch.last        = olast_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= otpc_pkg::VB_W'(otpc_pkg::WORD_BYTES))
    else $error("word byte count out of range");
  a_last_is_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT && last_r) |-> ph_r == P_CRC)
    else $error("final word emitted before crc");
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ost_r != otpc_pkg::ST_OK) |-> (ovb_r == '0 && olast_r))
    else $error("error result carries bytes");
  a_fix_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_READ) |-> fix_r <= otpc_pkg::FIX_LAST + 6'd1)
    else $error("fixed byte index past table");
endmodule
